[rtl/core/coulomb_counter_autorange_macros.svh]
// ----------------------------------------------------------------------------
// Coulomb counter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef COULOMB_COUNTER_AUTORANGE_MACROS_SVH
`define COULOMB_COUNTER_AUTORANGE_MACROS_SVH

// check a condition at every edge
`define CCA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the same cycle
`define CCA_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

[rtl/core/cca_pkg.sv]
// ----------------------------------------------------------------------------
// Coulomb counter package
// Widths, constants, codes and shared types of the coulomb counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

  localparam int OFFSET_W   = 10;
  localparam int GAIN_W     = 8;
  localparam int RAW_W      = 11;
  localparam int VALUE_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CH_W       = 2;
  localparam int SAMP_W     = 16;
  localparam int CUR_W      = 16;
  localparam int SUM_W      = CUR_W + 2;
  localparam int INTEG_W    = 20;
  localparam int MAH_W      = 16;
  localparam int AH_W       = 16;
  localparam int SUB_W      = 10;
  localparam int CAP_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 32;

  localparam int DECIMATION      = 25;
  localparam int IDX_W           = $clog2(DECIMATION + 1);
  localparam int INTEG_THRESHOLD = 366601;
  localparam int SWITCH_LEVEL    = 470;
  localparam int HYSTERESIS      = 35;
  localparam int SUB_WRAP        = 1000;
  localparam int CAP_SCALE       = 10;

  localparam logic [IDX_W-1:0] DECIM_N = IDX_W'(DECIMATION);

  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET_CAP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SET_DIS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3   = 3'd7;

  localparam logic [CH_W-1:0] CH_CHG_FINE   = 2'd0;
  localparam logic [CH_W-1:0] CH_DIS_FINE   = 2'd1;
  localparam logic [CH_W-1:0] CH_CHG_COARSE = 2'd2;
  localparam logic [CH_W-1:0] CH_DIS_COARSE = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]  next_channel;
    logic             discharging;
    logic [MAH_W-1:0] mah;
    logic [AH_W-1:0]  total_discharge;
    logic [AH_W-1:0]  total_charge;
    logic [CUR_W-1:0] last_current;
  } snap_t;

  // packed from the top bit down; matches out_tdata
  typedef struct packed {
    logic [CUR_W-1:0] current_10ma;
    logic [AH_W-1:0]  total_charge_ah;
    logic [AH_W-1:0]  total_discharge_ah;
    logic [CAP_W-1:0] capacity_10mah;
    logic             discharging;
    logic [CH_W-1:0]  next_channel;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/cca_scale.sv]
// ----------------------------------------------------------------------------
// Coulomb counter result scaling
// Turns a state snapshot into the reported capacity and current figures.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_scale (
  input  wire cca_pkg::snap_t snap,
  output cca_pkg::res_t       res
);

  localparam int DIV10_RECIP  = 52429;
  localparam int DIV10_SHIFT  = 19;
  localparam int DIV25_RECIP  = 1311;
  localparam int DIV25_SHIFT  = 15;
  localparam int PRE_SHIFT    = 4;
  localparam int Q400_W       = 8;
  localparam int PRE_W        = cca_pkg::CUR_W - PRE_SHIFT;
  localparam int P25_W        = PRE_W + 11;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    return x[15] ? (16'd0 - x) : x;
  endfunction

  function automatic logic [cca_pkg::CAP_W-1:0] div10(input logic [15:0] m);
    logic [31:0] p;
    p = {16'd0, m} * 32'(DIV10_RECIP);
    return p[DIV10_SHIFT +: cca_pkg::CAP_W];
  endfunction

  logic [15:0]               cap_mag;
  logic [cca_pkg::CAP_W-1:0] cap_q;
  logic [15:0]               cur_mag;
  logic [cca_pkg::CAP_W-1:0] cur_q10;
  logic [P25_W-1:0]          cur_p25;
  logic [Q400_W-1:0]         cur_q400;
  logic [cca_pkg::CAP_W-1:0] cur_diff;

  always_comb begin
    cap_mag  = mag16(snap.mah);
    cap_q    = div10(cap_mag);
    cur_mag  = mag16(snap.last_current);
    cur_q10  = div10(cur_mag);
    cur_p25  = P25_W'(cur_mag[15:PRE_SHIFT]) * P25_W'(DIV25_RECIP);
    cur_q400 = cur_p25[DIV25_SHIFT +: Q400_W];
    cur_diff = cur_q10 - cca_pkg::CAP_W'(cur_q400);

    res.next_channel       = snap.next_channel;
    res.discharging        = snap.discharging;
    res.total_discharge_ah = snap.total_discharge;
    res.total_charge_ah    = snap.total_charge;
    res.capacity_10mah     = snap.mah[15] ? (cca_pkg::CAP_W'(0) - cap_q) : cap_q;
    res.current_10ma       = snap.last_current[15] ?
                             (16'd0 - {3'b000, cur_diff}) : {3'b000, cur_diff};
  end

endmodule

`default_nettype wire

[rtl/core/coulomb_counter_autorange.sv]
// ----------------------------------------------------------------------------
// Coulomb counter with automatic shunt range
// Corrects ADC readings, decimates, integrates charge and picks the channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake; in_tuser is the mode (sample, clear
//           counter, set capacity, set total discharge), in_tdata the ADC
//           reading and the value operand.
//   out_* : exactly one result item per input item, in order: next channel,
//           direction, capacity, Ah totals and scaled current.
//   cfg_* : offset and gain writes, always ready; write only while idle.
// Throughput: one item per cycle unless out_tready stalls the output. The
//   corrected sample, decimation sum, integrator and channel choice all
//   settle combinationally from the input register, since each item needs
//   the channel the previous one chose.
// Pipeline: input register, state snapshot register, scaling into the output register.
// Reset: gains return to 1, offsets to 0, the counter state to zero (the coarse
//   flag starts set) with the first decimation block one sample short; output empty.
// Stall: a held result keeps its item; up to two more items sit in the
//   pipeline, then in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coulomb_counter_autorange_macros.svh"

module coulomb_counter_autorange (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [10:0] raw_sample, [27:11] value, [31:28] zero
  input  wire logic [cca_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] mode
  input  wire logic [cca_pkg::MODE_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] next_channel, [2] discharging, [15:3] capacity_10mah,
  // [31:16] total_discharge_ah, [47:32] total_charge_ah, [63:48] current_10ma
  output logic [$bits(cca_pkg::res_t)-1:0]      out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IW = cca_pkg::INTEG_W;
  localparam logic signed [IW:0] THR_POS = (IW+1)'(cca_pkg::INTEG_THRESHOLD);
  localparam logic signed [IW:0] THR_NEG = (IW+1)'(0) - THR_POS;
  localparam logic [cca_pkg::SAMP_W:0] LEVEL_LOW =
    (cca_pkg::SAMP_W+1)'(cca_pkg::SWITCH_LEVEL - cca_pkg::HYSTERESIS);
  localparam logic [cca_pkg::SAMP_W:0] LEVEL_HIGH =
    (cca_pkg::SAMP_W+1)'(cca_pkg::SWITCH_LEVEL + cca_pkg::HYSTERESIS);
  localparam logic [cca_pkg::SUB_W-1:0] SUB_N = cca_pkg::SUB_W'(cca_pkg::SUB_WRAP);

  // configuration
  logic [cca_pkg::OFFSET_W-1:0] offset_r [4];
  logic [cca_pkg::GAIN_W-1:0]   gain_r   [4];

  // pipeline
  logic                         in_valid_r;
  logic [cca_pkg::MODE_W-1:0]   in_mode_r;
  logic [cca_pkg::RAW_W-1:0]    in_raw_r;
  logic [cca_pkg::VALUE_W-1:0]  in_value_r;
  logic                         snap_valid_r;
  cca_pkg::snap_t               snap_r;
  cca_pkg::snap_t               snap_nxt;
  logic                         out_valid_r;
  cca_pkg::res_t                out_r;
  cca_pkg::res_t                res;
  logic                         out_free;
  logic                         snap_free;
  logic                         in_adv;
  logic                         snap_adv;

  // counter state
  logic [cca_pkg::CH_W-1:0]     sel_ch_r,  sel_ch_nxt;
  logic                         dir_r,     dir_nxt;
  logic                         coarse_r,  coarse_nxt;
  logic [cca_pkg::SUM_W-1:0]    dsum_r,    dsum_nxt;
  logic [cca_pkg::IDX_W-1:0]    didx_r,    didx_nxt;
  logic signed [IW-1:0]         integ_r,   integ_nxt;
  logic [cca_pkg::MAH_W-1:0]    mah_r,     mah_nxt;
  logic [cca_pkg::SUB_W-1:0]    dsub_r,    dsub_nxt;
  logic [cca_pkg::SUB_W-1:0]    csub_r,    csub_nxt;
  logic [cca_pkg::AH_W-1:0]     tdis_r,    tdis_nxt;
  logic [cca_pkg::AH_W-1:0]     tchg_r,    tchg_nxt;
  logic [cca_pkg::CUR_W-1:0]    cur_r,     cur_nxt;

  // sample path
  logic [cca_pkg::OFFSET_W-1:0] off_sel;
  logic [cca_pkg::GAIN_W-1:0]   gain_sel;
  logic signed [cca_pkg::RAW_W:0] diff;
  logic signed [cca_pkg::RAW_W+cca_pkg::GAIN_W+1:0] prod;
  logic signed [cca_pkg::SAMP_W-1:0] samp;
  logic [cca_pkg::SAMP_W:0]     mag;
  logic [cca_pkg::SUM_W-1:0]    sum_add;
  logic [cca_pkg::IDX_W-1:0]    idx_inc;
  logic signed [cca_pkg::CUR_W-1:0] cur16;
  logic signed [IW:0]           integ_sum;
  logic [cca_pkg::SUB_W-1:0]    csub_inc;
  logic [cca_pkg::SUB_W-1:0]    dsub_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        offset_r[i] <= '0;
        gain_r[i]   <= cca_pkg::GAIN_W'(1);
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        cca_pkg::REG_OFFSET_CH0: offset_r[0] <= cfg_data;
        cca_pkg::REG_OFFSET_CH1: offset_r[1] <= cfg_data;
        cca_pkg::REG_OFFSET_CH2: offset_r[2] <= cfg_data;
        cca_pkg::REG_OFFSET_CH3: offset_r[3] <= cfg_data;
        cca_pkg::REG_GAIN_CH0:   gain_r[0]   <= cfg_data[cca_pkg::GAIN_W-1:0];
        cca_pkg::REG_GAIN_CH1:   gain_r[1]   <= cfg_data[cca_pkg::GAIN_W-1:0];
        cca_pkg::REG_GAIN_CH2:   gain_r[2]   <= cfg_data[cca_pkg::GAIN_W-1:0];
        cca_pkg::REG_GAIN_CH3:   gain_r[3]   <= cfg_data[cca_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign out_free  = !out_valid_r || out_tready;
  assign snap_free = !snap_valid_r || out_free;
  assign in_tready = !in_valid_r || snap_free;
  assign in_adv    = in_valid_r && snap_free;
  assign snap_adv  = snap_valid_r && out_free;

  always_comb begin
    off_sel   = offset_r[sel_ch_r];
    gain_sel  = gain_r[sel_ch_r];
    diff      = $signed({in_raw_r[cca_pkg::RAW_W-1], in_raw_r}) -
                $signed({2'b00, off_sel});
    prod      = diff * $signed({1'b0, gain_sel});
    samp      = prod[cca_pkg::SAMP_W-1:0];
    mag       = samp[cca_pkg::SAMP_W-1] ? ((cca_pkg::SAMP_W+1)'(0) - {1'b1, samp})
                                         : {1'b0, samp};
    sum_add   = dsum_r + cca_pkg::SUM_W'(samp);
    idx_inc   = didx_r + cca_pkg::IDX_W'(1);
    cur16     = sum_add[cca_pkg::SUM_W-1:2];
    integ_sum = $signed({integ_r[IW-1], integ_r}) + (IW+1)'(cur16);
    csub_inc  = csub_r + cca_pkg::SUB_W'(1);
    dsub_inc  = dsub_r + cca_pkg::SUB_W'(1);

    sel_ch_nxt = sel_ch_r;
    dir_nxt    = dir_r;
    coarse_nxt = coarse_r;
    dsum_nxt   = dsum_r;
    didx_nxt   = didx_r;
    integ_nxt  = integ_r;
    mah_nxt    = mah_r;
    dsub_nxt   = dsub_r;
    csub_nxt   = csub_r;
    tdis_nxt   = tdis_r;
    tchg_nxt   = tchg_r;
    cur_nxt    = cur_r;

    case (in_mode_r)
      cca_pkg::MODE_SAMPLE: begin
        if (samp > 0) begin
          dir_nxt = 1'b0;
        end else if (samp < 0) begin
          dir_nxt = 1'b1;
        end else begin
          dir_nxt = !dir_r;
        end

        if (idx_inc >= cca_pkg::DECIM_N) begin
          dsum_nxt = '0;
          didx_nxt = '0;
          cur_nxt  = cur16;
          if (integ_sum >= THR_POS) begin
            integ_nxt = IW'(integ_sum - THR_POS);
            mah_nxt   = mah_r + cca_pkg::MAH_W'(1);
            if (csub_inc >= SUB_N) begin
              csub_nxt = '0;
              tchg_nxt = tchg_r + cca_pkg::AH_W'(1);
            end else begin
              csub_nxt = csub_inc;
            end
          end else if (integ_sum <= THR_NEG) begin
            integ_nxt = IW'(integ_sum + THR_POS);
            mah_nxt   = mah_r - cca_pkg::MAH_W'(1);
            if (dsub_inc >= SUB_N) begin
              dsub_nxt = '0;
              tdis_nxt = tdis_r + cca_pkg::AH_W'(1);
            end else begin
              dsub_nxt = dsub_inc;
            end
          end else begin
            integ_nxt = IW'(integ_sum);
          end
        end else begin
          dsum_nxt = sum_add;
          didx_nxt = idx_inc;
        end

        if (mag < (coarse_r ? LEVEL_LOW : LEVEL_HIGH)) begin
          coarse_nxt = 1'b0;
          sel_ch_nxt = dir_nxt ? cca_pkg::CH_DIS_FINE : cca_pkg::CH_CHG_FINE;
        end else begin
          coarse_nxt = 1'b1;
          sel_ch_nxt = dir_nxt ? cca_pkg::CH_DIS_COARSE : cca_pkg::CH_CHG_COARSE;
        end
      end
      cca_pkg::MODE_CLEAR: begin
        mah_nxt = '0;
      end
      cca_pkg::MODE_SET_CAP: begin
        mah_nxt = in_value_r[cca_pkg::MAH_W-1:0] * cca_pkg::MAH_W'(cca_pkg::CAP_SCALE);
      end
      cca_pkg::MODE_SET_DIS: begin
        tdis_nxt = in_value_r[cca_pkg::AH_W-1:0];
      end
      default: ;
    endcase

    snap_nxt.next_channel    = sel_ch_nxt;
    snap_nxt.discharging     = dir_nxt;
    snap_nxt.mah             = mah_nxt;
    snap_nxt.total_discharge = tdis_nxt;
    snap_nxt.total_charge    = tchg_nxt;
    snap_nxt.last_current    = cur_nxt;
  end

  cca_scale u_scale (
    .snap (snap_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      sel_ch_r     <= cca_pkg::CH_CHG_FINE;
      dir_r        <= 1'b0;
      coarse_r     <= 1'b1;
      dsum_r       <= '0;
      didx_r       <= cca_pkg::IDX_W'(1);
      integ_r      <= '0;
      mah_r        <= '0;
      dsub_r       <= '0;
      csub_r       <= '0;
      tdis_r       <= '0;
      tchg_r       <= '0;
      cur_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (snap_free) begin
        snap_valid_r <= in_valid_r;
      end
      if (out_free) begin
        out_valid_r <= snap_valid_r;
      end
      if (in_adv) begin
        sel_ch_r <= sel_ch_nxt;
        dir_r    <= dir_nxt;
        coarse_r <= coarse_nxt;
        dsum_r   <= dsum_nxt;
        didx_r   <= didx_nxt;
        integ_r  <= integ_nxt;
        mah_r    <= mah_nxt;
        dsub_r   <= dsub_nxt;
        csub_r   <= csub_nxt;
        tdis_r   <= tdis_nxt;
        tchg_r   <= tchg_nxt;
        cur_r    <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r  <= in_tuser;
      in_raw_r   <= in_tdata[cca_pkg::RAW_W-1:0];
      in_value_r <= in_tdata[cca_pkg::RAW_W +: cca_pkg::VALUE_W];
    end
    if (in_adv) begin
      snap_r <= snap_nxt;
    end
    if (snap_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `CCA_ASSERT_IMPLY(a_ready_when_out_empty, !out_valid_r, in_tready, "input stalled with empty output")
  `CCA_ASSERT_ALWAYS(a_integ_in_band, (integ_r < THR_POS) && (integ_r > THR_NEG), "integrator out of band")
  `CCA_ASSERT_ALWAYS(a_decim_index, didx_r < cca_pkg::DECIM_N, "decimation index overran")
  `CCA_ASSERT_ALWAYS(a_sub_counts, (csub_r < SUB_N) && (dsub_r < SUB_N), "sub-counter overran")

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Coulomb counter testbench
// Streams ADC samples and mode items into the counter and predicts every
// result item in order: corrected sample, direction, decimation, integrator
// crossings, Ah totals and channel hysteresis. Covers register extremes,
// random biased runs under random idling, a long output hold-off and
// integrator crossings in both directions.
// ----------------------------------------------------------------------------
module tb_top;
  import cca_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int CUR_SCALE    = 10;
  localparam int CUR_TRIM     = 400;
  localparam int CROSS_GUARD  = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = MODE_SAMPLE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [$bits(res_t)-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_OFFSET_CH0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  coulomb_counter_autorange i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted counter state and register shadows
  logic [OFFSET_W-1:0] reg_offset [4];
  logic [GAIN_W-1:0]   reg_gain [4];
  logic [CH_W-1:0]     cc_ch;
  logic                cc_dir;
  logic                cc_coarse;
  logic [31:0]         cc_sum;
  int                  cc_idx;
  int                  cc_integ;
  logic [MAH_W-1:0]    cc_mah;
  int                  cc_dsub;
  int                  cc_csub;
  logic [AH_W-1:0]     cc_tdis;
  logic [AH_W-1:0]     cc_tchg;
  logic [CUR_W-1:0]    cc_cur;

  res_t pending_reports [$];
  int   send_gap_pct = 26;
  int   sink_stall_pct = 52;
  bit   hold_request = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** coulomb_counter_autorange: FAILED **");
      $finish;
    end
  end

  task automatic reset_prediction();
    int ch;
    for (ch = 0; ch < 4; ch++) begin
      reg_offset[ch] = '0;
      reg_gain[ch]   = GAIN_W'(1);
    end
    cc_ch     = CH_CHG_FINE;
    cc_dir    = 1'b0;
    cc_coarse = 1'b1;
    cc_sum    = '0;
    cc_idx    = 1;
    cc_integ  = 0;
    cc_mah    = '0;
    cc_dsub   = 0;
    cc_csub   = 0;
    cc_tdis   = '0;
    cc_tchg   = '0;
    cc_cur    = '0;
  endtask

  function automatic res_t advance_counter(logic [MODE_W-1:0] mode, logic [RAW_W-1:0] raw,
                                           logic [VALUE_W-1:0] val);
    int diff, s_int, mag, level, cap, cur;
    logic [31:0] prod, shifted;
    logic signed [SAMP_W-1:0] s16;
    res_t r;
    case (mode)
      MODE_SAMPLE: begin
        diff  = int'($signed(raw)) - int'(reg_offset[cc_ch]);
        prod  = diff * int'(reg_gain[cc_ch]);
        s16   = prod[SAMP_W-1:0];
        s_int = s16;
        if (s_int > 0) cc_dir = 1'b0;
        else if (s_int < 0) cc_dir = 1'b1;
        else cc_dir = ~cc_dir;
        cc_sum = cc_sum + s_int;
        cc_idx++;
        if (cc_idx >= DECIMATION) begin
          shifted  = $signed(cc_sum) >>> 2;
          cc_idx   = 0;
          cc_sum   = '0;
          cc_cur   = shifted[CUR_W-1:0];
          cc_integ = cc_integ + int'($signed(cc_cur));
          if (cc_integ >= INTEG_THRESHOLD) begin
            cc_integ = cc_integ - INTEG_THRESHOLD;
            cc_mah   = cc_mah + 1'b1;
            cc_csub++;
            if (cc_csub >= SUB_WRAP) begin
              cc_csub = 0;
              cc_tchg = cc_tchg + 1'b1;
            end
          end else if (cc_integ <= -INTEG_THRESHOLD) begin
            cc_integ = cc_integ + INTEG_THRESHOLD;
            cc_mah   = cc_mah - 1'b1;
            cc_dsub++;
            if (cc_dsub >= SUB_WRAP) begin
              cc_dsub = 0;
              cc_tdis = cc_tdis + 1'b1;
            end
          end
        end
        mag   = (s_int < 0) ? -s_int : s_int;
        level = cc_coarse ? SWITCH_LEVEL - HYSTERESIS : SWITCH_LEVEL + HYSTERESIS;
        if (mag < level) begin
          cc_coarse = 1'b0;
          cc_ch     = cc_dir ? CH_DIS_FINE : CH_CHG_FINE;
        end else begin
          cc_coarse = 1'b1;
          cc_ch     = cc_dir ? CH_DIS_COARSE : CH_CHG_COARSE;
        end
      end
      MODE_CLEAR: begin
        cc_mah = '0;
      end
      MODE_SET_CAP: begin
        prod   = val[AH_W-1:0] * CAP_SCALE;
        cc_mah = prod[MAH_W-1:0];
      end
      default: begin
        cc_tdis = val[AH_W-1:0];
      end
    endcase
    cap = int'($signed(cc_mah)) / CAP_SCALE;
    cur = int'($signed(cc_cur));
    cur = cur / CUR_SCALE - cur / CUR_TRIM;
    r.next_channel       = cc_ch;
    r.discharging        = cc_dir;
    r.capacity_10mah     = cap[CAP_W-1:0];
    r.total_discharge_ah = cc_tdis;
    r.total_charge_ah    = cc_tchg;
    r.current_10ma       = cur[CUR_W-1:0];
    return r;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [RAW_W-1:0] raw,
                           logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DATA_W - VALUE_W - RAW_W){1'b0}}, val, raw};
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(advance_counter(mode, raw, val));
    items_sent++;
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_OFFSET_CH3) reg_offset[idx[1:0]] = data;
    else reg_gain[idx[1:0]] = data[GAIN_W-1:0];
  endtask

  task automatic configure_channel(int ch, int off, int gain);
    write_reg(REG_OFFSET_CH0 + CFG_IDX_W'(ch), CFG_DATA_W'(off));
    write_reg(REG_GAIN_CH0 + CFG_IDX_W'(ch), CFG_DATA_W'(gain));
  endtask

  task automatic configure_all(int off, int gain);
    int ch;
    for (ch = 0; ch < 4; ch++) configure_channel(ch, off, gain);
  endtask

  task automatic randomize_registers();
    int ch, off;
    for (ch = 0; ch < 4; ch++) begin
      off = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(63);
      configure_channel(ch, off, $urandom_range(255));
    end
  endtask

  task automatic check_field(string name, logic [CUR_W-1:0] want, logic [CUR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t got, want;
    got = out_tdata;
    results_checked++;
    if (pending_reports.size() == 0) begin
      $error("result item with nothing expected");
      mismatches++;
    end else begin
      want = pending_reports.pop_front();
      check_field("next_channel", want.next_channel, got.next_channel);
      check_field("discharging", want.discharging, got.discharging);
      check_field("capacity_10mah", want.capacity_10mah, got.capacity_10mah);
      check_field("total_discharge_ah", want.total_discharge_ah, got.total_discharge_ah);
      check_field("total_charge_ah", want.total_charge_ah, got.total_charge_ah);
      check_field("current_10ma", want.current_10ma, got.current_10ma);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic test_modes_and_hysteresis();
    send_item(MODE_CLEAR, '0, '0);
    // zero samples toggle the direction
    send_item(MODE_SAMPLE, 11'sd0, '0);
    send_item(MODE_SAMPLE, 11'sd0, '0);
    send_item(MODE_SAMPLE, 11'sd1023, '0);
    // hold coarse at the lower level, drop to fine below it
    send_item(MODE_SAMPLE, 11'sd435, '0);
    send_item(MODE_SAMPLE, 11'sd434, '0);
    send_item(MODE_SAMPLE, 11'sd504, '0);
    send_item(MODE_SAMPLE, 11'sd505, '0);
    send_item(MODE_SAMPLE, -11'sd1024, '0);
    send_item(MODE_SAMPLE, -11'sd434, '0);
    send_item(MODE_SET_CAP, 11'h7FF, 17'h0FFFF);
    send_item(MODE_SET_CAP, '0, 17'h18000);
    send_item(MODE_SET_CAP, 11'h7FF, 17'd3276);
    send_item(MODE_SET_CAP, '0, 17'd3277);
    send_item(MODE_SET_DIS, '0, 17'h0FFFF);
    send_item(MODE_SET_DIS, 11'h7FF, 17'h1FFFF);
    send_item(MODE_SET_DIS, '0, '0);
    send_item(MODE_CLEAR, 11'h7FF, 17'h1FFFF);
  endtask

  task automatic test_register_extremes();
    configure_all(0, 255);
    send_item(MODE_SAMPLE, 11'sd1023, '0);
    send_item(MODE_SAMPLE, -11'sd1024, '0);
    send_item(MODE_SAMPLE, 11'sd0, '0);
    configure_all(1023, 0);
    send_item(MODE_SAMPLE, 11'sd1023, '0);
    send_item(MODE_SAMPLE, -11'sd1024, '0);
    configure_all(1023, 255);
    send_item(MODE_SAMPLE, -11'sd1024, '0);
    send_item(MODE_SAMPLE, 11'sd1023, '0);
    send_item(MODE_SAMPLE, 11'sd0, '0);
  endtask

  task automatic test_random_traffic(int count);
    int done, k, run_len, bias, spread, r, sv;
    logic [MODE_W-1:0] m;
    logic [RAW_W-1:0] raw;
    logic [VALUE_W-1:0] v;
    done = 0;
    while (done < count) begin
      run_len = $urandom_range(150, 20);
      bias    = int'($urandom_range(2047)) - 1024;
      spread  = $urandom_range(80);
      for (k = 0; k < run_len && done < count; k++) begin
        r = $urandom_range(99);
        if (r < 88) m = MODE_SAMPLE;
        else if (r < 92) m = MODE_CLEAR;
        else if (r < 96) m = MODE_SET_CAP;
        else m = MODE_SET_DIS;
        if ($urandom_range(9) == 0) begin
          raw = RAW_W'($urandom);
        end else begin
          sv = bias + int'($urandom_range(2 * spread)) - spread;
          if (sv > 1023) sv = 1023;
          if (sv < -1024) sv = -1024;
          raw = sv[RAW_W-1:0];
        end
        sv = int'($urandom_range(98303)) - 32768;
        v  = sv[VALUE_W-1:0];
        send_item(m, raw, v);
        done++;
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    hold_request = 1'b1;
    for (k = 0; k < 60; k++) send_item(MODE_SAMPLE, RAW_W'($urandom), '0);
  endtask

  task automatic test_integrator_crossing();
    int n;
    logic [MAH_W-1:0] start_mah;
    configure_all(0, 5);
    // drive full charge current until the counter steps up
    start_mah = cc_mah;
    n = 0;
    while (cc_mah == start_mah && n < CROSS_GUARD) begin
      send_item(MODE_SAMPLE, 11'sd1023, '0);
      n++;
    end
    // then full discharge current until it steps down
    start_mah = cc_mah;
    n = 0;
    while (cc_mah == start_mah && n < CROSS_GUARD) begin
      send_item(MODE_SAMPLE, -11'sd1024, '0);
      n++;
    end
  endtask

  initial begin
    reset_prediction();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_modes_and_hysteresis();
    randomize_registers();
    test_random_traffic(400);

    send_gap_pct   = 52;
    sink_stall_pct = 26;
    test_register_extremes();
    randomize_registers();
    test_random_traffic(400);
    test_backpressure();

    send_gap_pct   = 0;
    sink_stall_pct = 0;
    randomize_registers();
    test_random_traffic(300);
    test_integrator_crossing();

    drain_pipeline();
    if (pending_reports.size() != 0) begin
      $error("%0d result items never arrived", pending_reports.size());
      mismatches++;
    end
    $display("Sent %0d items in all four modes; %0d results checked, %0d mismatches.",
             items_sent, results_checked, mismatches);
    $display("Swept offsets and gains to their limits, hysteresis, a long output hold-off"
             , " and mAh steps in both directions.");
    if (mismatches == 0) begin
      $display("** coulomb_counter_autorange: PASSED **");
    end else begin
      $display("** coulomb_counter_autorange: FAILED **");
    end
    $finish;
  end

endmodule
